// ===== rtl/exl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// exl_pkg
// Shared types and constants of the expression lexer: token kinds, character
// codes, the token record and the per-character token bundle.
// ----------------------------------------------------------------------------
package exl_pkg;

    localparam int NAME_CHARS_DEF = 8;
    localparam int TOK_FIFO_DEPTH = 8;
    localparam int TOK_SLOTS      = 4;
    localparam int TOK_MAX_PER_CH = 3;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // token kinds
    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_OPEN   = 3'd2;
    localparam logic [2:0] KIND_CLOSE  = 3'd3;
    localparam logic [2:0] KIND_OPER   = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;

    // character codes
    localparam logic [7:0] CH_NONE   = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] num;
        logic        ovf;
        logic [7:0]  op;
        logic [63:0] chars;
        logic [7:0]  len;
        logic [7:0]  bad;
        logic        last;
    } token_t;

    // slot 0: pending token closed by the character, slot 1: the character's
    // own token, slot 2: pending token closed by the line end, slot 3: end
    typedef struct packed {
        logic [TOK_SLOTS-1:0]         valid;
        token_t [TOK_SLOTS-1:0]       tok;
    } tok_bundle_t;

endpackage
`default_nettype wire

// ===== rtl/exl_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// exl_scan
// Input register and scanner state: classifies one character per cycle while
// the queue has room, updates number/name accumulators, builds up to three tokens.
// ----------------------------------------------------------------------------
module exl_scan #(
    parameter int NAME_CHARS = exl_pkg::NAME_CHARS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_stall,
    input  wire logic [7:0]          char_code,
    input  wire logic                line_end,
    input  wire logic                room,
    output logic                     push,
    output exl_pkg::tok_bundle_t     bundle
);
    import exl_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_NUM  = 4'b0010,
        MODE_NAME = 4'b0100,
        MODE_SKIP = 4'b1000
    } mode_t;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  char_reg;
    logic        end_reg;

    mode_t       mode_reg, mode_next, mode_m;
    logic        unary_reg, unary_next, unary_m;
    logic [30:0] acc_reg, acc_next, acc_m;
    logic        sat_reg, sat_next, sat_m;
    logic [63:0] buf_reg, buf_next, buf_m, buf_app;
    logic [7:0]  cnt_reg, cnt_next, cnt_m;

    logic        accept;
    logic        is_digit, is_alpha, is_space, is_oper, active;
    logic [3:0]  dig_val;
    logic [34:0] prod;

    function automatic token_t flush_token(mode_t m, logic [30:0] acc, logic sat,
                                           logic [63:0] nbuf, logic [7:0] cnt);
        token_t t;
        t = '0;
        if (m == MODE_NUM)
        begin
            t.kind = KIND_NUMBER;
            t.num  = acc;
            t.ovf  = sat;
        end
        else
        begin
            t.kind  = KIND_NAME;
            t.chars = nbuf;
            t.len   = cnt;
        end
        return t;
    endfunction

    assign accept     = char_valid && !char_stall;
    assign push       = in_valid_reg && room;
    assign char_stall = in_valid_reg && !room;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (push)
            in_valid_next = 1'b0;
    end

    assign is_digit = char_reg >= CH_ZERO && char_reg <= CH_NINE;
    assign is_alpha = (char_reg >= CH_UP_A && char_reg <= CH_UP_Z)
                   || (char_reg >= CH_LOW_A && char_reg <= CH_LOW_Z);
    assign is_space = char_reg == CH_SPACE || (char_reg >= CH_TAB && char_reg <= CH_CR);
    assign is_oper  = char_reg == CH_PLUS || char_reg == CH_MINUS || char_reg == CH_STAR
                   || char_reg == CH_SLASH || char_reg == CH_CARET;
    assign active   = char_reg != CH_NONE && mode_reg != MODE_SKIP;
    assign dig_val  = 4'(char_reg - CH_ZERO);

    // acc * 10 + digit, as two shifts and adds
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {31'b0, dig_val};

    always_comb
    begin
        buf_app = buf_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (i < NAME_CHARS && cnt_reg == 8'(i))
                buf_app[8*i +: 8] = char_reg;
        end
    end

    always_comb
    begin
        bundle  = '0;
        mode_m  = mode_reg;
        unary_m = unary_reg;
        acc_m   = acc_reg;
        sat_m   = sat_reg;
        buf_m   = buf_reg;
        cnt_m   = cnt_reg;

        if (active)
        begin
            if (is_digit && mode_reg == MODE_NUM)
            begin
                if (sat_reg || prod > {4'b0, NUM_MAX})
                begin
                    acc_m = NUM_MAX;
                    sat_m = 1'b1;
                end
                else
                begin
                    acc_m = prod[30:0];
                end
            end
            else if (is_alpha && mode_reg == MODE_NAME)
            begin
                buf_m = buf_app;
                if (cnt_reg != 8'hFF)
                    cnt_m = cnt_reg + 8'd1;
            end
            else
            begin
                // close the pending number or name
                if (mode_reg == MODE_NUM || mode_reg == MODE_NAME)
                begin
                    bundle.valid[0] = 1'b1;
                    bundle.tok[0]   = flush_token(mode_reg, acc_reg, sat_reg, buf_reg, cnt_reg);
                    unary_m         = 1'b0;
                end
                mode_m = MODE_IDLE;
                acc_m  = '0;
                sat_m  = 1'b0;
                buf_m  = '0;
                cnt_m  = '0;

                if (is_space)
                begin
                    mode_m = MODE_IDLE;
                end
                else if (is_digit)
                begin
                    mode_m = MODE_NUM;
                    acc_m  = {27'b0, dig_val};
                end
                else if (is_alpha)
                begin
                    mode_m = MODE_NAME;
                    buf_m  = {56'b0, char_reg};
                    cnt_m  = 8'd1;
                end
                else if (char_reg == CH_OPEN)
                begin
                    bundle.valid[1]   = 1'b1;
                    bundle.tok[1].kind = KIND_OPEN;
                    bundle.tok[1].op   = char_reg;
                    unary_m           = 1'b1;
                end
                else if (char_reg == CH_CLOSE)
                begin
                    bundle.valid[1]   = 1'b1;
                    bundle.tok[1].kind = KIND_CLOSE;
                    bundle.tok[1].op   = char_reg;
                    unary_m           = 1'b0;
                end
                else if (is_oper)
                begin
                    // unary plus is dropped, unary minus becomes tilde
                    if (!(unary_m && char_reg == CH_PLUS))
                    begin
                        bundle.valid[1]    = 1'b1;
                        bundle.tok[1].kind = KIND_OPER;
                        bundle.tok[1].op   = (unary_m && char_reg == CH_MINUS) ? CH_TILDE
                                                                               : char_reg;
                    end
                    unary_m = 1'b1;
                end
                else
                begin
                    bundle.valid[1]    = 1'b1;
                    bundle.tok[1].kind = KIND_ERROR;
                    bundle.tok[1].bad  = char_reg;
                    mode_m             = MODE_SKIP;
                end
            end
        end

        mode_next  = mode_m;
        unary_next = unary_m;
        acc_next   = acc_m;
        sat_next   = sat_m;
        buf_next   = buf_m;
        cnt_next   = cnt_m;

        if (end_reg)
        begin
            if (mode_m == MODE_NUM || mode_m == MODE_NAME)
            begin
                bundle.valid[2] = 1'b1;
                bundle.tok[2]   = flush_token(mode_m, acc_m, sat_m, buf_m, cnt_m);
            end
            bundle.valid[3]     = 1'b1;
            bundle.tok[3].kind  = KIND_END;
            bundle.tok[3].last  = 1'b1;
            mode_next  = MODE_IDLE;
            unary_next = 1'b1;
            acc_next   = '0;
            sat_next   = 1'b0;
            buf_next   = '0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            unary_reg    <= 1'b1;
            acc_reg      <= '0;
            sat_reg      <= 1'b0;
            buf_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (push)
            begin
                mode_reg  <= mode_next;
                unary_reg <= unary_next;
                acc_reg   <= acc_next;
                sat_reg   <= sat_next;
                buf_reg   <= buf_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
            end_reg  <= line_end;
        end
    end

    a_line_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        push && end_reg |=> mode_reg == MODE_IDLE && unary_reg && cnt_reg == 8'd0)
        else $error("scanner state not cleared after line end");

    a_token_limit: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> $countones(bundle.valid) <= TOK_MAX_PER_CH)
        else $error("more than three tokens from one character");

    a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> acc_reg == NUM_MAX)
        else $error("saturated accumulator not at maximum");

endmodule
`default_nettype wire

// ===== rtl/exl_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// exl_fifo
// Token queue: takes up to four token slots per cycle, packed in order,
// and hands out one token beat per cycle while token_stall is low.
// ----------------------------------------------------------------------------
module exl_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire exl_pkg::tok_bundle_t bundle,
    output logic                      room,
    output logic                      token_valid,
    input  wire logic                 token_stall,
    output exl_pkg::token_t           head
);
    import exl_pkg::*;

    localparam int PTR_W = $clog2(TOK_FIFO_DEPTH);
    localparam int CNT_W = $clog2(TOK_FIFO_DEPTH + 1);

    token_t             mem_reg [TOK_FIFO_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   slot_idx [TOK_SLOTS];
    logic [CNT_W-1:0]   push_cnt;
    logic               pop;

    always_comb
    begin
        push_cnt = '0;
        for (int i = 0; i < TOK_SLOTS; i++)
        begin
            slot_idx[i] = wptr_reg + PTR_W'(push_cnt);
            if (bundle.valid[i])
                push_cnt = push_cnt + CNT_W'(1);
        end
    end

    assign room        = count_reg <= CNT_W'(TOK_FIFO_DEPTH - TOK_MAX_PER_CH);
    assign token_valid = count_reg != '0;
    assign pop         = token_valid && !token_stall;
    assign head        = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + PTR_W'(push_cnt) : wptr_reg;
        rptr_next  = pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        count_next = count_reg + (push ? push_cnt : CNT_W'(0)) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOK_SLOTS; i++)
        begin
            if (push && bundle.valid[i])
                mem_reg[slot_idx[i]] <= bundle.tok[i];
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TOK_FIFO_DEPTH))
        else $error("token queue over capacity");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> {1'b0, count_reg} + {1'b0, push_cnt} <= (CNT_W+1)'(TOK_FIFO_DEPTH))
        else $error("push exceeds free space");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        PTR_W'(wptr_reg - rptr_reg) == PTR_W'(count_reg))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== rtl/expression_lexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming tokenizer for arithmetic expressions: one character per beat in,
// one token per beat out.
// ----------------------------------------------------------------------------
// Timing: an accepted character is held in the input register and scanned
//   there; once the queue has room, its tokens are written into the queue
//   and the first of them is offered from then on.
// Throughput: one character per cycle and, unless stalled, one token per cycle;
//   a character waits in the input register while the token queue has fewer
//   than three free slots, so the output port sets the pace for token-dense input.
// Reset: rst_n clears the queue and puts the scanner at line start.
// ----------------------------------------------------------------------------
module expression_lexer #(
    parameter int NAME_CHARS = exl_pkg::NAME_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character channel
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        line_end,
    // token channel
    output logic             token_valid,
    input  wire logic        token_stall,
    output logic [2:0]       token_kind,
    output logic [30:0]      number_value,
    output logic             number_overflow,
    output logic [7:0]       operator_char,
    output logic [63:0]      name_chars,
    output logic [7:0]       name_length,
    output logic [7:0]       bad_char,
    output logic             last_of_line
);
    import exl_pkg::*;

    logic        room;
    logic        push;
    tok_bundle_t bundle;
    token_t      head;

    // Scanner: input register, lexer state and the per-character token bundle.
    // It advances only when the queue can take a full bundle.
    exl_scan #(
        .NAME_CHARS (NAME_CHARS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .line_end   (line_end),
        .room       (room),
        .push       (push),
        .bundle     (bundle)
    );

    // Token queue: packs the bundle's valid slots in order and drains one
    // token per beat, so the scanner keeps going while a token waits.
    exl_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .bundle      (bundle),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .head        (head)
    );

    // Fan the head token out to the payload ports.
    assign token_kind      = head.kind;
    assign number_value    = head.num;
    assign number_overflow = head.ovf;
    assign operator_char   = head.op;
    assign name_chars      = head.chars;
    assign name_length     = head.len;
    assign bad_char        = head.bad;
    assign last_of_line    = head.last;

endmodule
`default_nettype wire

// ===== dv/expression_lexer_tb.sv =====
// ----------------------------------------------------------------------------
// expression_lexer_tb
// Self-checking bench for the expression lexer. A driver feeds characters
// from a queue of pending beats, a token predictor computes the tokens each
// accepted character must cause, and a monitor compares every token taken
// from the block against the oldest prediction, field by field. Stimulus is
// a short directed set, then mostly well-formed random expressions mixed
// with broken lines and raw noise, under three idling profiles.
// ----------------------------------------------------------------------------
module expression_lexer_tb;

    import exl_pkg::*;

    // one pending character beat; a drain entry holds the driver until every
    // predicted token has come out
    typedef struct packed {
        logic       drain;
        logic       ends;
        logic [7:0] code;
    } char_beat_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_NAME,
        SCAN_SKIP
    } scan_mode_t;

    localparam logic [7:0] BIN_OPS [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    // printable characters the lexer rejects: '#', '.', '=', '!'
    localparam logic [7:0] STRAY [4]   = '{8'h23, 8'h2E, 8'h3D, 8'h21};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  char_code = CH_NONE;
    logic        line_end = 1'b0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    logic [2:0]  token_kind;
    logic [30:0] number_value;
    logic        number_overflow;
    logic [7:0]  operator_char;
    logic [63:0] name_chars;
    logic [7:0]  name_length;
    logic [7:0]  bad_char;
    logic        last_of_line;

    char_beat_t  pending_beats [$];
    token_t      expected_tokens [$];
    int          beats_pushed = 0;
    int          error_count = 0;
    int          send_idle_pct = 21;
    int          recv_idle_pct = 84;

    // token predictor state
    scan_mode_t  lex_mode;
    logic        at_operand_start;
    logic [30:0] value_acc;
    logic        value_sat;
    logic [63:0] name_acc;
    logic [7:0]  name_len;

    expression_lexer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_valid      (char_valid),
        .char_stall      (char_stall),
        .char_code       (char_code),
        .line_end        (line_end),
        .token_valid     (token_valid),
        .token_stall     (token_stall),
        .token_kind      (token_kind),
        .number_value    (number_value),
        .number_overflow (number_overflow),
        .operator_char   (operator_char),
        .name_chars      (name_chars),
        .name_length     (name_length),
        .bad_char        (bad_char),
        .last_of_line    (last_of_line)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------------
    function automatic token_t token_of(logic [2:0] kind, logic [7:0] op);
        token_t t;
        t = '0;
        t.kind = kind;
        t.op = op;
        return t;
    endfunction

    task automatic reset_lexer();
        lex_mode = SCAN_IDLE;
        at_operand_start = 1'b1;
        value_acc = '0;
        value_sat = 1'b0;
        name_acc = '0;
        name_len = '0;
    endtask

    // Emit the number or name under construction, if any. Skip mode survives
    // so that an error keeps swallowing the rest of the line.
    task automatic close_pending();
        token_t t;
        if (lex_mode == SCAN_NUMBER)
        begin
            t = token_of(KIND_NUMBER, CH_NONE);
            t.num = value_acc;
            t.ovf = value_sat;
            expected_tokens.push_back(t);
            at_operand_start = 1'b0;
        end
        else if (lex_mode == SCAN_NAME)
        begin
            t = token_of(KIND_NAME, CH_NONE);
            t.chars = name_acc;
            t.len = name_len;
            expected_tokens.push_back(t);
            at_operand_start = 1'b0;
        end
        if (lex_mode != SCAN_SKIP)
            lex_mode = SCAN_IDLE;
        value_acc = '0;
        value_sat = 1'b0;
        name_acc = '0;
        name_len = '0;
    endtask

    task automatic lex_char(input logic [7:0] c, input logic ends);
        logic            is_digit;
        logic            is_alpha;
        logic            is_blank;
        longint unsigned grown;
        token_t          t;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        is_alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z);
        is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        if (c != CH_NONE && lex_mode != SCAN_SKIP)
        begin
            if (is_digit && lex_mode == SCAN_NUMBER)
            begin
                grown = 64'(value_acc) * 64'd10 + 64'(c - CH_ZERO);
                if (value_sat || grown > 64'(NUM_MAX))
                begin
                    value_acc = NUM_MAX;
                    value_sat = 1'b1;
                end
                else
                    value_acc = grown[30:0];
            end
            else if (is_alpha && lex_mode == SCAN_NAME)
            begin
                // characters past the buffer only count toward the length
                if (int'(name_len) < NAME_CHARS_DEF)
                    name_acc[8*name_len +: 8] = c;
                if (name_len != 8'hFF)
                    name_len = name_len + 8'd1;
            end
            else
            begin
                close_pending();
                if (is_blank)
                begin
                    // whitespace only ends the pending token
                end
                else if (is_digit)
                begin
                    lex_mode = SCAN_NUMBER;
                    value_acc = 31'(c - CH_ZERO);
                end
                else if (is_alpha)
                begin
                    lex_mode = SCAN_NAME;
                    name_acc = {56'd0, c};
                    name_len = 8'd1;
                end
                else if (c == CH_OPEN)
                begin
                    expected_tokens.push_back(token_of(KIND_OPEN, c));
                    at_operand_start = 1'b1;
                end
                else if (c == CH_CLOSE)
                begin
                    expected_tokens.push_back(token_of(KIND_CLOSE, c));
                    at_operand_start = 1'b0;
                end
                else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET})
                begin
                    // sign in operand position: minus turns unary, plus vanishes
                    if (at_operand_start && c == CH_MINUS)
                        expected_tokens.push_back(token_of(KIND_OPER, CH_TILDE));
                    else if (!(at_operand_start && c == CH_PLUS))
                        expected_tokens.push_back(token_of(KIND_OPER, c));
                    at_operand_start = 1'b1;
                end
                else
                begin
                    t = token_of(KIND_ERROR, CH_NONE);
                    t.bad = c;
                    expected_tokens.push_back(t);
                    lex_mode = SCAN_SKIP;
                end
            end
        end
        if (ends)
        begin
            close_pending();
            t = token_of(KIND_END, CH_NONE);
            t.last = 1'b1;
            expected_tokens.push_back(t);
            reset_lexer();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_char(input logic [7:0] code, input logic ends = 1'b0);
        char_beat_t b;
        b = '0;
        b.code = code;
        b.ends = ends;
        pending_beats.push_back(b);
        beats_pushed++;
    endtask

    task automatic push_drain();
        char_beat_t b;
        b = '0;
        b.drain = 1'b1;
        pending_beats.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // end the line on its last character or on a separate empty beat
    task automatic close_line();
        char_beat_t b;
        if ($urandom_range(0, 1))
        begin
            b = pending_beats.pop_back();
            b.ends = 1'b1;
            pending_beats.push_back(b);
        end
        else
            push_char(CH_NONE, 1'b1);
    endtask

    task automatic maybe_blank();
        case ($urandom_range(0, 7))
            0:       push_char(CH_SPACE);
            1:       push_char(8'($urandom_range(CH_TAB, CH_CR)));
            2:       push_char(CH_NONE);
            default: ;
        endcase
    endtask

    task automatic push_name(input int len);
        repeat (len)
            push_char(8'($urandom_range(0, 1) ? $urandom_range(CH_UP_A, CH_UP_Z)
                                              : $urandom_range(CH_LOW_A, CH_LOW_Z)));
    endtask

    task automatic gen_number();
        case ($urandom_range(0, 15))
            0:       push_text("2147483647");
            1:       push_text("2147483648");
            2, 3:    repeat ($urandom_range(10, 14))
                         push_char(8'($urandom_range(CH_ZERO, CH_NINE)));
            default: repeat ($urandom_range(1, 4))
                         push_char(8'($urandom_range(CH_ZERO, CH_NINE)));
        endcase
    endtask

    task automatic gen_operand(input int depth);
        int pick;
        pick = $urandom_range(0, 9);
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            push_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        if (depth < 2 && pick == 0)
        begin
            push_char(CH_OPEN);
            maybe_blank();
            gen_expr(depth + 1);
            maybe_blank();
            push_char(CH_CLOSE);
        end
        else if (pick < 6)
            gen_number();
        else
            push_name($urandom_range(0, 5) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6));
    endtask

    task automatic gen_expr(input int depth);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++)
        begin
            gen_operand(depth);
            if (i != terms - 1)
            begin
                maybe_blank();
                push_char(BIN_OPS[$urandom_range(0, 4)]);
                maybe_blank();
            end
        end
    endtask

    // Mostly well-formed lines; some broken by a rejected character mid-line,
    // the rest raw bytes with line ends sprinkled in.
    task automatic queue_random_line();
        int shape;
        shape = $urandom_range(0, 9);
        maybe_blank();
        if (shape <= 6)
            gen_expr(0);
        else if (shape == 7)
        begin
            gen_expr(0);
            maybe_blank();
            push_char($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                           : STRAY[$urandom_range(0, 3)]);
            gen_expr(0);
        end
        else
            repeat ($urandom_range(1, 10))
                push_char(8'($urandom_range(0, shape == 8 ? 255 : 127)),
                          $urandom_range(0, 5) == 0);
        close_line();
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || char_valid || expected_tokens.size() != 0)
            @(posedge clk);
        // let a character with no token of its own clear the pipeline
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict on acceptance, then load the next beat when the slot
    // is free. A stalled beat is held untouched.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_beat_t next_beat;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_code <= CH_NONE;
            line_end <= 1'b0;
        end
        else
        begin
            if (char_valid && !char_stall)
                lex_char(char_code, line_end);
            if (!char_valid || !char_stall)
            begin
                if (pending_beats.size() != 0 && pending_beats[0].drain)
                begin
                    // hold the sender until every predicted token is out
                    if (expected_tokens.size() == 0)
                        next_beat = pending_beats.pop_front();
                    char_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_beat = pending_beats.pop_front();
                    char_valid <= 1'b1;
                    char_code <= next_beat.code;
                    line_end <= next_beat.ends;
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted token beat against the oldest prediction,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------------
    function automatic void check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        token_t want;
        if (!rst_n)
            token_stall <= 1'b0;
        else
        begin
            if (token_valid && !token_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token_kind: expected no token, got kind %0d", token_kind);
                    error_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", 64'(want.kind), 64'(token_kind));
                    check_field("number_value", 64'(want.num), 64'(number_value));
                    check_field("number_overflow", 64'(want.ovf), 64'(number_overflow));
                    check_field("operator_char", 64'(want.op), 64'(operator_char));
                    check_field("name_chars", want.chars, name_chars);
                    check_field("name_length", 64'(want.len), 64'(name_length));
                    check_field("bad_char", 64'(want.bad), 64'(bad_char));
                    check_field("last_of_line", 64'(want.last), 64'(last_of_line));
                end
            end
            token_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_lexer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unary minus at line start, unary plus after an open
        // bracket and after an operator, every binary operator, brackets,
        // letter and digit extremes, a number with a leading zero.
        push_text("-(+aZ^09)*A/8+7-+");
        push_char("1", 1'b1);
        // Whitespace, empty beats, a high invalid code that turns the rest
        // of the line into skipped characters, an empty line end.
        push_char(CH_TAB);
        push_char(CH_NONE);
        push_char(CH_CR);
        push_char(CH_SPACE);
        push_char(8'hFF);
        push_char("x");
        push_char(CH_NONE, 1'b1);
        push_drain();

        // sender mostly busy, receiver mostly stalled
        while (beats_pushed < 110)
            queue_random_line();
        wait_drained();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 84;
        recv_idle_pct = 21;
        while (beats_pushed < 140)
            queue_random_line();
        push_drain();
        while (beats_pushed < 165)
            queue_random_line();
        wait_drained();

        // no idling; include a name long enough to saturate its length
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_name(256);
        push_text("+1");
        close_line();
        while (beats_pushed < 460)
            queue_random_line();
        wait_drained();

        if (error_count == 0 && expected_tokens.size() == 0)
            $display("expression_lexer regression: pass");
        else
            $display("expression_lexer regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("expression_lexer regression: fail");
        $finish;
    end

endmodule

// ===== expression_lexer.f =====
rtl/exl_pkg.sv
rtl/exl_scan.sv
rtl/exl_fifo.sv
rtl/expression_lexer.sv
dv/expression_lexer_tb.sv
